@@ hdl/nps_pkg.sv @@
// Shared types and constants for the nearest-point leaf scan.
// No dependencies; imported by every module of the block except nps_fifo.
package nps_pkg;

  // Command codes carried by each input item
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  // Report sequencer states
  typedef enum logic [1:0] {
    RPT_IDLE,
    RPT_ROOT,
    RPT_BOX
  } rpt_state_e;

  localparam int unsigned DIST_BITS   = 26;              // Q14.12 distance
  localparam int unsigned SQ_BITS     = 2 * DIST_BITS;   // Q28.24 squared bound
  localparam int unsigned QUEUE_DEPTH = 4;               // front-to-back queue

endpackage

@@ hdl/nps_fifo.sv @@
// Small register-based queue between the front and back parts.
// Depends on nothing but its WIDTH and DEPTH parameters.
module nps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/nps_front.sv @@
// Front part: takes input items, drops unused commands, packs the rest
// into queue entries. Uses nps_pkg for command codes and field widths.
module nps_front #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned ENTRY_BITS = 2 + 3 * 24 + 16 + 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    command_i,
  input  logic signed [COORD_BITS-1:0]  coord_x_i,
  input  logic signed [COORD_BITS-1:0]  coord_y_i,
  input  logic signed [COORD_BITS-1:0]  coord_z_i,
  input  logic [INDEX_BITS-1:0]         point_index_i,
  input  logic [nps_pkg::DIST_BITS-1:0] start_distance_i,
  output logic                          q_push_o,
  input  logic                          q_full_i,
  output logic [ENTRY_BITS-1:0]         q_data_o
);

  import nps_pkg::*;

  logic                  valid_q, valid_d;
  logic [ENTRY_BITS-1:0] entry_q;
  logic                  accept, keep, drain;

  // unused command codes are taken and dropped here
  always_comb begin
    case (command_i)
      CMD_START, CMD_POINT, CMD_FINISH: keep = 1'b1;
      default:                          keep = 1'b0;
    endcase
  end

  assign drain  = valid_q && !q_full_i;
  assign full   = valid_q && q_full_i;
  assign accept = push && !full;

  always_comb begin
    valid_d = valid_q;
    if (drain) begin
      valid_d = 1'b0;
    end
    if (accept && keep) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      entry_q <= {command_i, coord_x_i, coord_y_i, coord_z_i, point_index_i, start_distance_i};
    end
  end

  assign q_push_o = valid_q;
  assign q_data_o = entry_q;

endmodule

@@ hdl/nps_back.sv @@
// Back part: three-stage distance pipeline (difference, square, sum and
// compare) that holds the sample point and the running best. Uses nps_pkg.
module nps_back #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned ENTRY_BITS = 2 + 3 * 24 + 16 + 26
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  logic [ENTRY_BITS-1:0]        q_data_i,
  output logic                         q_pop_o,
  output logic                         fin_valid_o,
  input  logic                         fin_ready_i,
  output logic                         have_best_o,
  output logic [INDEX_BITS-1:0]        best_point_o,
  output logic [nps_pkg::SQ_BITS-1:0]  best_sq_o,
  output logic signed [COORD_BITS-1:0] sample_x_o,
  output logic signed [COORD_BITS-1:0] sample_y_o,
  output logic signed [COORD_BITS-1:0] sample_z_o
);

  import nps_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned SW = 2 * CB + 2;                 // sum of three squares
  localparam int unsigned KW = (SW > SQ_BITS) ? SW : SQ_BITS;

  // queue head fields
  cmd_e                  h_cmd;
  logic signed [CB-1:0]  h_x, h_y, h_z;
  logic [INDEX_BITS-1:0] h_idx;
  logic [DIST_BITS-1:0]  h_dist;

  assign h_cmd  = cmd_e'(q_data_i[ENTRY_BITS-1 -: 2]);
  assign h_x    = q_data_i[ENTRY_BITS-3 -: CB];
  assign h_y    = q_data_i[ENTRY_BITS-3-CB -: CB];
  assign h_z    = q_data_i[ENTRY_BITS-3-2*CB -: CB];
  assign h_idx  = q_data_i[DIST_BITS +: INDEX_BITS];
  assign h_dist = q_data_i[DIST_BITS-1:0];

  // sample used by the difference stage, written when a start leaves the queue
  logic signed [CB-1:0] smp_x_q, smp_y_q, smp_z_q;

  // stage registers
  logic                  s1_v_q, s2_v_q, s3_v_q;
  cmd_e                  s1_cmd_q, s2_cmd_q, s3_cmd_q;
  logic [CB-1:0]         s1_dx_q, s1_dy_q, s1_dz_q;
  logic [DIST_BITS-1:0]  s1_dist_q;
  logic [INDEX_BITS-1:0] s1_idx_q, s2_idx_q, s3_idx_q;
  logic signed [CB-1:0]  s1_cx_q, s1_cy_q, s1_cz_q;
  logic signed [CB-1:0]  s2_cx_q, s2_cy_q, s2_cz_q;
  logic signed [CB-1:0]  s3_cx_q, s3_cy_q, s3_cz_q;
  logic [2*CB-1:0]       s2_sqx_q, s2_sqy_q, s2_sqz_q;
  logic [SQ_BITS-1:0]    s2_ssq_q, s3_ssq_q;
  logic [SW-1:0]         s3_sum_q;

  // running best, and the sample as seen at the compare stage
  logic [SQ_BITS-1:0]    best_q;
  logic [INDEX_BITS-1:0] point_q;
  logic                  have_q;
  logic signed [CB-1:0]  rep_x_q, rep_y_q, rep_z_q;

  logic          adv, pop, s3_fire, beats;
  logic [CB-1:0] dx_d, dy_d, dz_d;

  function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                             input logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    return d[CB] ? CB'(-d) : d[CB-1:0];
  endfunction

  // a finish waits at the compare stage until the report unit takes it
  assign fin_valid_o = s3_v_q && (s3_cmd_q == CMD_FINISH);
  assign adv         = !(fin_valid_o && !fin_ready_i);
  assign pop         = adv && !q_empty_i;
  assign q_pop_o     = pop;
  assign s3_fire     = s3_v_q && adv;

  assign dx_d  = abs_diff(h_x, smp_x_q);
  assign dy_d  = abs_diff(h_y, smp_y_q);
  assign dz_d  = abs_diff(h_z, smp_z_q);
  assign beats = KW'(s3_sum_q) < KW'(best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      smp_x_q <= '0;
      smp_y_q <= '0;
      smp_z_q <= '0;
      rep_x_q <= '0;
      rep_y_q <= '0;
      rep_z_q <= '0;
      best_q  <= '0;
      point_q <= '0;
      have_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= pop;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (pop && h_cmd == CMD_START) begin
        smp_x_q <= h_x;
        smp_y_q <= h_y;
        smp_z_q <= h_z;
      end
      if (s3_fire) begin
        case (s3_cmd_q)
          CMD_START: begin
            rep_x_q <= s3_cx_q;
            rep_y_q <= s3_cy_q;
            rep_z_q <= s3_cz_q;
            best_q  <= s3_ssq_q;
            point_q <= '0;
            have_q  <= 1'b0;
          end
          CMD_POINT: begin
            if (beats) begin
              best_q  <= SQ_BITS'(s3_sum_q);
              point_q <= s3_idx_q;
              have_q  <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q  <= h_cmd;
      s1_dx_q   <= dx_d;
      s1_dy_q   <= dy_d;
      s1_dz_q   <= dz_d;
      s1_dist_q <= h_dist;
      s1_idx_q  <= h_idx;
      s1_cx_q   <= h_x;
      s1_cy_q   <= h_y;
      s1_cz_q   <= h_z;

      s2_cmd_q  <= s1_cmd_q;
      s2_sqx_q  <= s1_dx_q * s1_dx_q;
      s2_sqy_q  <= s1_dy_q * s1_dy_q;
      s2_sqz_q  <= s1_dz_q * s1_dz_q;
      s2_ssq_q  <= s1_dist_q * s1_dist_q;
      s2_idx_q  <= s1_idx_q;
      s2_cx_q   <= s1_cx_q;
      s2_cy_q   <= s1_cy_q;
      s2_cz_q   <= s1_cz_q;

      s3_cmd_q  <= s2_cmd_q;
      s3_sum_q  <= SW'(s2_sqx_q) + SW'(s2_sqy_q) + SW'(s2_sqz_q);
      s3_ssq_q  <= s2_ssq_q;
      s3_idx_q  <= s2_idx_q;
      s3_cx_q   <= s2_cx_q;
      s3_cy_q   <= s2_cy_q;
      s3_cz_q   <= s2_cz_q;
    end
  end

  assign have_best_o  = have_q;
  assign best_point_o = point_q;
  assign best_sq_o    = best_q;
  assign sample_x_o   = rep_x_q;
  assign sample_y_o   = rep_y_q;
  assign sample_z_o   = rep_z_q;

endmodule

@@ hdl/nps_report.sv @@
// Report unit: bit-serial square root of the best squared distance, box
// around the sample, and the result register. Uses nps_pkg.
module nps_report #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fin_valid_i,
  output logic                          fin_ready_o,
  input  logic                          have_best_i,
  input  logic [INDEX_BITS-1:0]         best_point_i,
  input  logic [nps_pkg::SQ_BITS-1:0]   best_sq_i,
  input  logic signed [COORD_BITS-1:0]  sample_x_i,
  input  logic signed [COORD_BITS-1:0]  sample_y_i,
  input  logic signed [COORD_BITS-1:0]  sample_z_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          found_o,
  output logic [INDEX_BITS-1:0]         best_index_o,
  output logic [nps_pkg::DIST_BITS-1:0] best_distance_o,
  output logic signed [COORD_BITS-1:0]  box_min_x_o,
  output logic signed [COORD_BITS-1:0]  box_min_y_o,
  output logic signed [COORD_BITS-1:0]  box_min_z_o,
  output logic signed [COORD_BITS-1:0]  box_max_x_o,
  output logic signed [COORD_BITS-1:0]  box_max_y_o,
  output logic signed [COORD_BITS-1:0]  box_max_z_o
);

  import nps_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned BW   = ((CB > DIST_BITS) ? CB : DIST_BITS) + 2;
  localparam int unsigned RW   = DIST_BITS + 3;
  localparam int unsigned CNTW = $clog2(DIST_BITS);
  localparam logic signed [BW-1:0] CMAX = BW'(2 ** (CB - 1) - 1);
  localparam logic signed [BW-1:0] CMIN = ~CMAX;

  rpt_state_e state_q, state_d;

  logic                  load, step, out_load, last;
  logic                  found_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic signed [CB-1:0]  sx_q, sy_q, sz_q;
  logic [SQ_BITS-1:0]    data_q;
  logic [RW-1:0]         rem_q, rem_sh, trial;
  logic [DIST_BITS-1:0]  root_q;
  logic [CNTW-1:0]       cnt_q;

  logic                  out_v_q;
  logic                  o_found_q;
  logic [INDEX_BITS-1:0] o_idx_q;
  logic [DIST_BITS-1:0]  o_dist_q;
  logic [CB-1:0]         o_minx_q, o_miny_q, o_minz_q, o_maxx_q, o_maxy_q, o_maxz_q;

  logic signed [BW-1:0]  r_w, x_w, y_w, z_w;

  function automatic logic [CB-1:0] sat(input logic signed [BW-1:0] v);
    if (v > CMAX) begin
      return CMAX[CB-1:0];
    end else if (v < CMIN) begin
      return CMIN[CB-1:0];
    end
    return v[CB-1:0];
  endfunction

  assign last = (cnt_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      RPT_IDLE: if (fin_valid_i) state_d = have_best_i ? RPT_ROOT : RPT_BOX;
      RPT_ROOT: if (last) state_d = RPT_BOX;
      RPT_BOX:  if (!out_v_q || pop) state_d = RPT_IDLE;
      default:  state_d = RPT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    fin_ready_o = 1'b0;
    load        = 1'b0;
    step        = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      RPT_IDLE: begin
        fin_ready_o = 1'b1;
        load        = fin_valid_i;
      end
      RPT_ROOT: step = 1'b1;
      RPT_BOX:  out_load = !out_v_q || pop;
      default: begin
      end
    endcase
  end

  // one root bit per cycle, restoring form
  assign rem_sh = {rem_q[RW-3:0], data_q[SQ_BITS-1 -: 2]};
  assign trial  = RW'({root_q, 2'b01});

  assign r_w = $signed(BW'(root_q));
  assign x_w = BW'(sx_q);
  assign y_w = BW'(sy_q);
  assign z_w = BW'(sz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RPT_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q <= have_best_i;
      idx_q   <= best_point_i;
      sx_q    <= sample_x_i;
      sy_q    <= sample_y_i;
      sz_q    <= sample_z_i;
      data_q  <= best_sq_i;
      rem_q   <= '0;
      root_q  <= '0;
      cnt_q   <= CNTW'(DIST_BITS - 1);
    end else if (step) begin
      data_q <= {data_q[SQ_BITS-3:0], 2'b00};
      cnt_q  <= cnt_q - CNTW'(1);
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[DIST_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[DIST_BITS-2:0], 1'b0};
      end
    end
    if (out_load) begin
      o_found_q <= found_q;
      o_idx_q   <= found_q ? idx_q : '0;
      o_dist_q  <= found_q ? root_q : '0;
      o_minx_q  <= found_q ? sat(x_w - r_w) : '0;
      o_miny_q  <= found_q ? sat(y_w - r_w) : '0;
      o_minz_q  <= found_q ? sat(z_w - r_w) : '0;
      o_maxx_q  <= found_q ? sat(x_w + r_w) : '0;
      o_maxy_q  <= found_q ? sat(y_w + r_w) : '0;
      o_maxz_q  <= found_q ? sat(z_w + r_w) : '0;
    end
  end

  assign empty           = !out_v_q;
  assign found_o         = o_found_q;
  assign best_index_o    = o_idx_q;
  assign best_distance_o = o_dist_q;
  assign box_min_x_o     = o_minx_q;
  assign box_min_y_o     = o_miny_q;
  assign box_min_z_o     = o_minz_q;
  assign box_max_x_o     = o_maxx_q;
  assign box_max_y_o     = o_maxy_q;
  assign box_max_z_o     = o_maxz_q;

endmodule

@@ hdl/nearest_point_leaf_scan.sv @@
// Nearest-point leaf scan: top level. Start and candidate items are taken one per cycle while full is low.
// A start or candidate settles the best after it passes the input register, the queue and the
// three pipeline stages; a finish with a hit then runs the root steps and the box step.
// A finish stalls at the compare stage only while the report unit is busy with its root steps,
// its box step or a wait for pop.
// Reset (rst_ni, async, active low): sample, bound and best index clear to zero, queues empty.
module nearest_point_leaf_scan #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input side
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    command_i,
  input  logic signed [COORD_BITS-1:0]  coord_x_i,
  input  logic signed [COORD_BITS-1:0]  coord_y_i,
  input  logic signed [COORD_BITS-1:0]  coord_z_i,
  input  logic [INDEX_BITS-1:0]         point_index_i,
  input  logic [nps_pkg::DIST_BITS-1:0] start_distance_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          found_o,
  output logic [INDEX_BITS-1:0]         best_index_o,
  output logic [nps_pkg::DIST_BITS-1:0] best_distance_o,
  output logic signed [COORD_BITS-1:0]  box_min_x_o,
  output logic signed [COORD_BITS-1:0]  box_min_y_o,
  output logic signed [COORD_BITS-1:0]  box_min_z_o,
  output logic signed [COORD_BITS-1:0]  box_max_x_o,
  output logic signed [COORD_BITS-1:0]  box_max_y_o,
  output logic signed [COORD_BITS-1:0]  box_max_z_o
);

  import nps_pkg::*;

  // queue entry: command, three coordinates, index, distance
  localparam int unsigned EW = 2 + 3 * COORD_BITS + INDEX_BITS + DIST_BITS;

  logic                          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0]                 q_wdata, q_rdata;

  // back part to report unit: finish handoff and the state it reports
  logic                          fin_valid, fin_ready, have_best;
  logic [INDEX_BITS-1:0]         best_point;
  logic [SQ_BITS-1:0]            best_sq;
  logic signed [COORD_BITS-1:0]  smp_x, smp_y, smp_z;

  // front: input register, drops the unused command code
  nps_front #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS),
    .ENTRY_BITS (EW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .command_i        (command_i),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .coord_z_i        (coord_z_i),
    .point_index_i    (point_index_i),
    .start_distance_i (start_distance_i),
    .q_push_o         (q_push),
    .q_full_i         (q_full),
    .q_data_o         (q_wdata)
  );

  // decoupling queue so the front keeps taking items while a finish is reported
  nps_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  // back: difference, square, sum/compare; owns sample and best
  nps_back #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS),
    .ENTRY_BITS (EW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .fin_valid_o  (fin_valid),
    .fin_ready_i  (fin_ready),
    .have_best_o  (have_best),
    .best_point_o (best_point),
    .best_sq_o    (best_sq),
    .sample_x_o   (smp_x),
    .sample_y_o   (smp_y),
    .sample_z_o   (smp_z)
  );

  // report: square root, saturated box, result register
  nps_report #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_report (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fin_valid_i     (fin_valid),
    .fin_ready_o     (fin_ready),
    .have_best_i     (have_best),
    .best_point_i    (best_point),
    .best_sq_i       (best_sq),
    .sample_x_i      (smp_x),
    .sample_y_i      (smp_y),
    .sample_z_i      (smp_z),
    .empty           (empty),
    .pop             (pop),
    .found_o         (found_o),
    .best_index_o    (best_index_o),
    .best_distance_o (best_distance_o),
    .box_min_x_o     (box_min_x_o),
    .box_min_y_o     (box_min_y_o),
    .box_min_z_o     (box_min_z_o),
    .box_max_x_o     (box_max_x_o),
    .box_max_y_o     (box_max_y_o),
    .box_max_z_o     (box_max_z_o)
  );

endmodule

@@ tb/sv/nearest_point_leaf_scan_tb.sv @@
// Self-checking bench for nearest_point_leaf_scan: directed corner queries, then random
// start / candidate / finish sequences. Each report is predicted in the bench and compared.
// Depends on nps_pkg and the nearest_point_leaf_scan RTL only.
`timescale 1ns / 100ps

module nearest_point_leaf_scan_tb;
  import nps_pkg::*;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned INDEX_BITS = 16;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;      // no code in cmd_e; the block drops it
  localparam longint      COORD_HI   = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint      COORD_LO   = -COORD_HI - 1;
  localparam int unsigned DIST_MAX   = (1 << DIST_BITS) - 1;
  localparam int unsigned ITEMS      = 1300;
  localparam int unsigned HOLD_CYCLES = 400;      // long result-side stall
  localparam int unsigned TAIL_CYCLES = 64;       // drain time after the last item, past the pipe, root and box steps

  // One input item; drain marks a point where the sender waits for every report.
  typedef struct {
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] x, y, z;
    logic [INDEX_BITS-1:0]        idx;
    logic [DIST_BITS-1:0]         start_dist;
    bit                           drain;
  } leaf_cmd_t;

  typedef struct {
    bit                           found;
    logic [INDEX_BITS-1:0]        idx;
    logic [DIST_BITS-1:0]         root;
    logic signed [COORD_BITS-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         push = 1'b0;
  logic                         full;
  logic [1:0]                   command_i = CMD_START;
  logic signed [COORD_BITS-1:0] coord_x_i = '0;
  logic signed [COORD_BITS-1:0] coord_y_i = '0;
  logic signed [COORD_BITS-1:0] coord_z_i = '0;
  logic [INDEX_BITS-1:0]        point_index_i = '0;
  logic [DIST_BITS-1:0]         start_distance_i = '0;

  logic                         empty;
  logic                         pop = 1'b0;
  logic                         found_o;
  logic [INDEX_BITS-1:0]        best_index_o;
  logic [DIST_BITS-1:0]         best_distance_o;
  logic signed [COORD_BITS-1:0] box_min_x_o, box_min_y_o, box_min_z_o;
  logic signed [COORD_BITS-1:0] box_max_x_o, box_max_y_o, box_max_z_o;

  nearest_point_leaf_scan #(
    .COORD_BITS(COORD_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .point_index_i   (point_index_i),
    .start_distance_i(start_distance_i),
    .empty           (empty),
    .pop             (pop),
    .found_o         (found_o),
    .best_index_o    (best_index_o),
    .best_distance_o (best_distance_o),
    .box_min_x_o     (box_min_x_o),
    .box_min_y_o     (box_min_y_o),
    .box_min_z_o     (box_min_z_o),
    .box_max_x_o     (box_max_x_o),
    .box_max_y_o     (box_max_y_o),
    .box_max_z_o     (box_max_z_o)
  );

  // Stimulus waiting to go out, and reports predicted but not yet popped
  leaf_cmd_t leaf_cmds_q[$];
  report_t   report_q[$];
  leaf_cmd_t cur_item;

  // Bench copy of the search state
  longint          smp_x, smp_y, smp_z;
  longint unsigned bound_sq;
  logic [INDEX_BITS-1:0] hit_index;
  bit              have_hit;

  int unsigned n_made;          // items queued, unused commands excluded
  int unsigned n_items_acc;
  int unsigned n_finish_acc;
  int unsigned n_reports_seen;  // written with NBA so the driver reads a stable value
  int unsigned n_hits;
  int unsigned n_mismatch;
  int unsigned hold_left;
  bit          hold_done;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    smp_x = 0;
    smp_y = 0;
    smp_z = 0;
    bound_sq = 0;
    hit_index = '0;
    have_hit = 1'b0;
    n_made = 0;
    n_items_acc = 0;
    n_finish_acc = 0;
    n_reports_seen = 0;
    n_hits = 0;
    n_mismatch = 0;
    hold_left = 0;
    hold_done = 1'b0;
  end

  function automatic longint rand_coord();
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom());
    return v;
  endfunction

  function automatic void queue_cmd(logic [1:0] cmd, longint x, longint y, longint z,
                                    longint unsigned idx, longint unsigned start_dist);
    leaf_cmd_t c;
    c.cmd        = cmd;
    c.x          = x[COORD_BITS-1:0];
    c.y          = y[COORD_BITS-1:0];
    c.z          = z[COORD_BITS-1:0];
    c.idx        = idx[INDEX_BITS-1:0];
    c.start_dist = start_dist[DIST_BITS-1:0];
    c.drain      = 1'b0;
    leaf_cmds_q.push_back(c);
    if (cmd != CMD_UNUSED) n_made++;
  endfunction

  // Squared per-axis difference; at 24-bit coordinates the three-axis sum stays
  // below 2^50, so the 50-bit sum in the design never wraps here.
  function automatic longint unsigned axis_sq(longint a, longint b);
    longint d;
    d = a - b;
    return d * d;
  endfunction

  // Floor square root, one result bit per step from the top
  function automatic logic [DIST_BITS-1:0] floor_root(longint unsigned v);
    logic [DIST_BITS-1:0] acc, trial;
    longint unsigned      sq;
    acc = '0;
    for (int b = DIST_BITS - 1; b >= 0; b--) begin
      trial = acc | (DIST_BITS'(1) << b);
      sq = trial;
      sq = sq * trial;
      if (sq <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
    if (v > COORD_HI) return COORD_BITS'(COORD_HI);
    if (v < COORD_LO) return COORD_BITS'(COORD_LO);
    return v[COORD_BITS-1:0];
  endfunction

  // Apply one accepted item to the bench state; a finish queues its report
  function automatic void search_step(leaf_cmd_t c);
    longint unsigned dsq;
    longint          reach;
    report_t         r;
    case (c.cmd)
      CMD_START: begin
        smp_x = c.x;
        smp_y = c.y;
        smp_z = c.z;
        bound_sq = c.start_dist;
        bound_sq = bound_sq * bound_sq;
        hit_index = '0;
        have_hit = 1'b0;
      end
      CMD_POINT: begin
        dsq = axis_sq(c.x, smp_x) + axis_sq(c.y, smp_y) + axis_sq(c.z, smp_z);
        // strictly below: of equally near points the first one stays
        if (dsq < bound_sq) begin
          bound_sq = dsq;
          hit_index = c.idx;
          have_hit = 1'b1;
        end
      end
      CMD_FINISH: begin
        r = '{default: '0};
        if (have_hit) begin
          r.found = 1'b1;
          r.idx   = hit_index;
          r.root  = floor_root(bound_sq);
          reach   = r.root;
          r.min_x = clamp_coord(smp_x - reach);
          r.min_y = clamp_coord(smp_y - reach);
          r.min_z = clamp_coord(smp_z - reach);
          r.max_x = clamp_coord(smp_x + reach);
          r.max_y = clamp_coord(smp_y + reach);
          r.max_z = clamp_coord(smp_z + reach);
          n_hits++;
        end
        report_q.push_back(r);
      end
      default: ;  // unused command: no effect
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: report %0d field %s expected %0d, actual %0d",
               $time, n_reports_seen, name, want, got);
      n_mismatch++;
    end
  endfunction

  // Driver: holds push until the item is taken, idles ~30% between items except
  // for a calm stretch, and stops at a drain marker until all reports are back.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    bit taken;
    bit calm;
    if (!rst_ni) begin
      push             <= 1'b0;
      command_i        <= CMD_START;
      coord_x_i        <= '0;
      coord_y_i        <= '0;
      coord_z_i        <= '0;
      point_index_i    <= '0;
      start_distance_i <= '0;
    end else begin
      taken = push && !full;
      calm  = (n_items_acc >= 500) && (n_items_acc < 700);
      if (taken) begin
        search_step(cur_item);
        n_items_acc++;
        if (cur_item.cmd == CMD_FINISH) n_finish_acc++;
      end
      if (!push || taken) begin
        if (leaf_cmds_q.size() != 0 && leaf_cmds_q[0].drain &&
            n_finish_acc == n_reports_seen)
          void'(leaf_cmds_q.pop_front());
        if (leaf_cmds_q.size() != 0 && !leaf_cmds_q[0].drain &&
            (calm || $urandom_range(0, 99) >= 30)) begin
          cur_item = leaf_cmds_q.pop_front();
          push             <= 1'b1;
          command_i        <= cur_item.cmd;
          coord_x_i        <= cur_item.x;
          coord_y_i        <= cur_item.y;
          coord_z_i        <= cur_item.z;
          point_index_i    <= cur_item.idx;
          start_distance_i <= cur_item.start_dist;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each popped report against the oldest prediction; pops ~70%
  // of cycles, always during a calm stretch, and once holds off for a long while
  // so the result register stays full, the queue fills and full backs up into the sender.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    report_t want;
    bit      calm;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_reports_seen <= n_reports_seen + 1;
        if (report_q.size() == 0) begin
          $display("%0t: report with nothing expected, actual found=%0d index=%0d dist=%0d",
                   $time, found_o, best_index_o, best_distance_o);
          n_mismatch++;
        end else begin
          want = report_q.pop_front();
          check_field("found", want.found, found_o);
          check_field("best_index", want.idx, best_index_o);
          check_field("best_distance", want.root, best_distance_o);
          check_field("box_min_x", want.min_x, box_min_x_o);
          check_field("box_min_y", want.min_y, box_min_y_o);
          check_field("box_min_z", want.min_z, box_min_z_o);
          check_field("box_max_x", want.max_x, box_max_x_o);
          check_field("box_max_y", want.max_y, box_max_y_o);
          check_field("box_max_z", want.max_z, box_max_z_o);
        end
      end
      if (!hold_done && n_reports_seen == 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      calm = (n_reports_seen >= 60) && (n_reports_seen < 100);
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    leaf_cmd_t   hold_mark;
    longint      sx, sy, sz;
    int unsigned radius, spread, npts;
    hold_mark = '{default: '0};
    hold_mark.drain = 1'b1;

    // Candidate before any start: zero bound at the origin, never found
    queue_cmd(CMD_POINT, 0, 0, 0, 16'h0005, 0);
    queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);
    // Unused command with every field at an extreme: ignored
    queue_cmd(CMD_UNUSED, COORD_LO, COORD_HI, -1, 16'hFFFF, DIST_MAX);
    // Widest bound from the origin; far corners, then a tie that must lose
    queue_cmd(CMD_START, 0, 0, 0, 0, DIST_MAX);
    queue_cmd(CMD_POINT, COORD_HI, COORD_HI, COORD_HI, 16'hFFFF, 0);
    queue_cmd(CMD_POINT, COORD_LO, COORD_LO, COORD_LO, 0, DIST_MAX);
    queue_cmd(CMD_POINT, -COORD_HI, -COORD_HI, -COORD_HI, 16'h1234, 0);
    queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);       // box saturates both ways
    queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);       // repeated finish, same report
    // Candidates after a finish keep narrowing the same bound
    queue_cmd(CMD_POINT, 1, -1, 0, 16'h0042, 0);
    queue_cmd(CMD_UNUSED, 0, 0, 0, 16'h0007, 0);  // would be nearer, dropped
    queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);
    // Zero bound: even the sample itself does not beat it
    queue_cmd(CMD_START, COORD_HI, COORD_HI, COORD_HI, 0, 0);
    queue_cmd(CMD_POINT, COORD_HI, COORD_HI, COORD_HI, 16'h8000, 0);
    queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);
    // Bound of one: the sample itself is found at distance zero
    queue_cmd(CMD_START, COORD_LO, COORD_LO, COORD_LO, 16'hFFFF, 1);
    queue_cmd(CMD_POINT, COORD_LO, COORD_LO, COORD_LO, 16'hAAAA, 0);
    queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);
    // Opposite corners: widest difference on every axis
    queue_cmd(CMD_START, COORD_HI, COORD_LO, COORD_HI, 0, DIST_MAX);
    queue_cmd(CMD_POINT, COORD_LO, COORD_HI, COORD_LO, 16'h5555, DIST_MAX);
    queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);
    // Start and finish with no candidate in between
    queue_cmd(CMD_START, 4096, -4096, 12345, 0, 4096);
    queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);

    // Random queries: mostly start, points around the sample, finish
    for (int unsigned seq = 0; n_made < ITEMS; seq++) begin
      if (seq == 80) leaf_cmds_q.push_back(hold_mark);
      sx = rand_coord();
      sy = rand_coord();
      sz = rand_coord();
      case ($urandom_range(0, 4))
        0:       radius = $urandom_range(0, DIST_MAX);
        1:       radius = $urandom_range(0, 64);
        2:       radius = $urandom_range(0, 1 << 16);
        3:       radius = DIST_MAX;
        default: radius = $urandom_range(0, 1 << 22);
      endcase
      case ($urandom_range(0, 3))
        0:       spread = 4;
        1:       spread = 2048;
        2:       spread = 1 << 18;
        default: spread = 1 << 23;
      endcase
      // a few sequences skip the start and keep using the previous query
      if ($urandom_range(0, 19) != 0)
        queue_cmd(CMD_START, sx, sy, sz, $urandom_range(0, 65535), radius);
      npts = $urandom_range(0, 12);
      for (int unsigned k = 0; k < npts; k++) begin
        if ($urandom_range(0, 11) == 0)
          queue_cmd(CMD_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(0, 65535), $urandom_range(0, DIST_MAX));
        if ($urandom_range(0, 7) == 0)
          queue_cmd(CMD_POINT, rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(0, 65535), $urandom_range(0, DIST_MAX));
        else
          queue_cmd(CMD_POINT,
                    sx + longint'($urandom_range(0, 2 * spread)) - longint'(spread),
                    sy + longint'($urandom_range(0, 2 * spread)) - longint'(spread),
                    sz + longint'($urandom_range(0, 2 * spread)) - longint'(spread),
                    $urandom_range(0, 65535), $urandom_range(0, DIST_MAX));
      end
      if ($urandom_range(0, 15) != 0)
        queue_cmd(CMD_FINISH, rand_coord(), rand_coord(), rand_coord(),
                  $urandom_range(0, 65535), $urandom_range(0, DIST_MAX));
      if ($urandom_range(0, 9) == 0)
        queue_cmd(CMD_FINISH, 0, 0, 0, 0, 0);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (leaf_cmds_q.size() != 0 || push || report_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Ran %0d commands: %0d reports checked, %0d of them with a nearer point found.",
             n_items_acc, n_reports_seen, n_hits);
    $display("Covered ties, saturated boxes, zero bounds, repeated finishes and unused commands.");
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The slowest correct run of all items, with their root steps, stalls and the long hold,
  // ends well before this watchdog limit.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/nps_pkg.sv
hdl/nps_fifo.sv
hdl/nps_front.sv
hdl/nps_back.sv
hdl/nps_report.sv
hdl/nearest_point_leaf_scan.sv
tb/sv/nearest_point_leaf_scan_tb.sv
